[hw/rtl/lktc_pkg.sv]
`default_nettype none

package lktc_pkg;

	// Width of the time fields on the ports.
	localparam int FIELD_W = 32;

	// Default arithmetic width of the time path.
	localparam int TIME_WIDTH_DEF = 32;

	// Loop modes; codes four to seven are invalid.
	typedef enum logic [2:0] {
		MODE_CLAMP    = 3'd0,
		MODE_INFINITE = 3'd1,
		MODE_REPEAT   = 3'd2,
		MODE_PINGPONG = 3'd3
	} mode_t;

	// Result status codes.
	localparam logic [1:0] ST_CONTINUE = 2'd0;
	localparam logic [1:0] ST_ENDED    = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;

	// One request item.
	typedef struct packed {
		logic [2:0]         mode;
		logic [FIELD_W-1:0] elapsed_time;
		logic [FIELD_W-1:0] loop_length;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [FIELD_W-1:0] key_time;
		logic [1:0]         status;
	} rsp_t;

	// Per-item control that rides along the divider stages.
	typedef struct packed {
		logic [2:0] mode;
		logic       gt;   // time is greater than the length
		logic       lz;   // length is zero
	} ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/lktc_prep.sv]
`default_nettype none

module lktc_prep #(
	parameter int W = lktc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          valid_in,
	input  wire lktc_pkg::req_t req,
	output logic               valid_s1,
	output lktc_pkg::ctrl_t    ctrl_s1,
	output logic [W-1:0]       t_s1,
	output logic [W-1:0]       len_s1
);

	logic [W-1:0] t_m;
	logic [W-1:0] len_m;

	// Trim both times to the arithmetic width.
	assign t_m   = req.elapsed_time[W-1:0];
	assign len_m = req.loop_length[W-1:0];

	// Valid bit of the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	// Compare time against length once, up front.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s1.mode <= req.mode;
			ctrl_s1.gt   <= (t_m > len_m);
			ctrl_s1.lz   <= (len_m == '0);
			t_s1         <= t_m;
			len_s1       <= len_m;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lktc_div_step.sv]
`default_nettype none

module lktc_div_step #(
	parameter int W       = lktc_pkg::TIME_WIDTH_DEF,
	parameter int BIT_IDX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            valid_in,
	input  wire lktc_pkg::ctrl_t ctrl_in,
	input  wire logic [W-1:0]    t_in,
	input  wire logic [W-1:0]    len_in,
	input  wire logic [W-1:0]    rem_in,
	output logic                 valid_s,
	output lktc_pkg::ctrl_t      ctrl_s,
	output logic [W-1:0]         t_s,
	output logic [W-1:0]         len_s,
	output logic [W-1:0]         rem_s,
	output logic                 qbit_s
);

	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;

	// One restoring step: bring down the next dividend bit, subtract if it fits.
	assign trial = {rem_in, t_in[BIT_IDX]};
	assign diff  = trial - {1'b0, len_in};
	assign ge    = (trial >= {1'b0, len_in});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (adv) begin
			valid_s <= valid_in;
		end
	end

	// The new remainder is below the length, so it fits in W bits.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s <= ctrl_in;
			t_s    <= t_in;
			len_s  <= len_in;
			rem_s  <= ge ? diff[W-1:0] : trial[W-1:0];
			qbit_s <= ge;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lktc_finish.sv]
`default_nettype none

module lktc_finish #(
	parameter int W = lktc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            valid_in,
	input  wire lktc_pkg::ctrl_t ctrl_in,
	input  wire logic [W-1:0]    t_in,
	input  wire logic [W-1:0]    len_in,
	input  wire logic [W-1:0]    rem_in,
	input  wire logic            q_odd,
	output logic                 rsp_valid_q,
	output lktc_pkg::rsp_t       rsp_q
);

	logic [W-1:0] key;
	logic [1:0]   status;

	// Pick the key time and status by loop mode.
	always_comb begin
		key    = '0;
		status = lktc_pkg::ST_CONTINUE;
		case (ctrl_in.mode)
			lktc_pkg::MODE_CLAMP: begin
				if (ctrl_in.gt) begin
					key    = len_in;
					status = lktc_pkg::ST_ENDED;
				end else begin
					key = t_in;
				end
			end
			lktc_pkg::MODE_INFINITE: begin
				key = t_in;
			end
			lktc_pkg::MODE_REPEAT: begin
				if (ctrl_in.lz) begin
					key = '0;
				end else if (ctrl_in.gt) begin
					key = rem_in;
				end else begin
					key = t_in;
				end
			end
			lktc_pkg::MODE_PINGPONG: begin
				if (!ctrl_in.gt) begin
					key = t_in;
				end else if (ctrl_in.lz) begin
					key = '0;
				end else if (q_odd) begin
					key = len_in - rem_in;
				end else begin
					key = rem_in;
				end
			end
			default: begin
				key    = '0;
				status = lktc_pkg::ST_INVALID;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.key_time <= lktc_pkg::FIELD_W'(key);
			rsp_q.status   <= status;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/loop_key_time_calc.sv]
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | lktc_pkg::req_t (mode, elapsed_time, loop_length)
// rsp     | out       | rsp_valid / rsp_stall  | lktc_pkg::rsp_t (key_time, status)
//
// One request enters every cycle while req_stall is low. W below is TIME_WIDTH capped
// at the 32-bit field width.
// The compare register takes the request, then W restoring stages follow, one quotient
// bit each, and the output register closes the path.
// Reset clears every valid bit; the data registers are not reset.
// While a response is stalled the whole pipeline freezes and req_stall is high.
`default_nettype none

module loop_key_time_calc #(
	parameter int TIME_WIDTH = lktc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire lktc_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output lktc_pkg::rsp_t      rsp
);

	localparam int W = (TIME_WIDTH < lktc_pkg::FIELD_W) ? TIME_WIDTH : lktc_pkg::FIELD_W;

	logic            adv;
	logic            valid_p [0:W];
	lktc_pkg::ctrl_t ctrl_p  [0:W];
	logic [W-1:0]    t_p     [0:W];
	logic [W-1:0]    len_p   [0:W];
	logic [W-1:0]    rem_p   [0:W];
	logic            qbit_p  [1:W];

	// The pipeline moves unless a finished response is being held.
	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	// Compare stage.
	lktc_prep #(.W(W)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_in (req_valid),
		.req      (req),
		.valid_s1 (valid_p[0]),
		.ctrl_s1  (ctrl_p[0]),
		.t_s1     (t_p[0]),
		.len_s1   (len_p[0])
	);

	assign rem_p[0] = '0;

	// Divider stages, most significant quotient bit first.
	for (genvar k = 0; k < W; k++) begin : g_step
		lktc_div_step #(.W(W), .BIT_IDX(W - 1 - k)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (valid_p[k]),
			.ctrl_in  (ctrl_p[k]),
			.t_in     (t_p[k]),
			.len_in   (len_p[k]),
			.rem_in   (rem_p[k]),
			.valid_s  (valid_p[k+1]),
			.ctrl_s   (ctrl_p[k+1]),
			.t_s      (t_p[k+1]),
			.len_s    (len_p[k+1]),
			.rem_s    (rem_p[k+1]),
			.qbit_s   (qbit_p[k+1])
		);
	end

	// Mode select and output register; the last quotient bit gives the parity.
	lktc_finish #(.W(W)) u_finish (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.valid_in    (valid_p[W]),
		.ctrl_in     (ctrl_p[W]),
		.t_in        (t_p[W]),
		.len_in      (len_p[W]),
		.rem_in      (rem_p[W]),
		.q_odd       (qbit_p[W]),
		.rsp_valid_q (rsp_valid),
		.rsp_q       (rsp)
	);

endmodule

`default_nettype wire

[hw/rtl/lktc_checker.sv]
`default_nettype none

module lktc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire lktc_pkg::rsp_t rsp
);

	// A held response keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Requests are only held off while a response is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held response");

	// Status stays within its three codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == lktc_pkg::ST_CONTINUE ||
			rsp.status == lktc_pkg::ST_ENDED || rsp.status == lktc_pkg::ST_INVALID)
		else $error("unknown status code");

	// An invalid mode answers with a zero key time.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == lktc_pkg::ST_INVALID |-> rsp.key_time == '0)
		else $error("invalid mode gave nonzero key time");

endmodule

bind loop_key_time_calc lktc_checker u_lktc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

[verif/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lktc_pkg::*;

	// The divider has one stage per bit, plus the compare and output stages.
	localparam int PIPE_LAT    = FIELD_W + 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTS  = 50;

	// Mode codes that answer with the invalid status.
	localparam logic [2:0] MODE_BAD_LO = 3'd4;
	localparam logic [2:0] MODE_BAD_HI = 3'd7;

	localparam logic [FIELD_W-1:0] T_MAX = '1;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	bit          req_idle_on = 1'b1;
	bit          rsp_idle_on = 1'b1;
	bit          hold_on     = 1'b0;
	int unsigned rsp_gap     = 0;
	int unsigned cycle_cnt   = 0;
	int unsigned err_cnt     = 0;

	// Key times and status codes still owed by the block, oldest first.
	rsp_t expected_keys[$];

	loop_key_time_calc dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Map one request onto its key time and status.
	function automatic rsp_t loop_key_of(req_t r);
		logic [FIELD_W-1:0] t;
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] quot;
		logic [FIELD_W-1:0] rem;
		rsp_t               o;
		t          = r.elapsed_time;
		len        = r.loop_length;
		o.key_time = '0;
		o.status   = ST_CONTINUE;
		case (r.mode)
			MODE_CLAMP: begin
				if (t > len) begin
					o.key_time = len;
					o.status   = ST_ENDED;
				end else begin
					o.key_time = t;
				end
			end
			MODE_INFINITE: begin
				o.key_time = t;
			end
			MODE_REPEAT: begin
				if (len == '0)
					o.key_time = '0;
				else if (t > len)
					o.key_time = t % len;
				else
					o.key_time = t;
			end
			MODE_PINGPONG: begin
				if (t <= len) begin
					o.key_time = t;
				end else if (len == '0) begin
					o.key_time = '0;
				end else begin
					quot       = t / len;
					rem        = t % len;
					o.key_time = quot[0] ? len - rem : rem;
				end
			end
			default: begin
				o.status = ST_INVALID;
			end
		endcase
		return o;
	endfunction

	function automatic req_t make_req(logic [2:0] m, logic [FIELD_W-1:0] t,
			logic [FIELD_W-1:0] len);
		req_t r;
		r.mode         = m;
		r.elapsed_time = t;
		r.loop_length  = len;
		return r;
	endfunction

	// Requests often aim at the loop boundaries, multiples of the length and zero length.
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		if ($urandom_range(0, 99) < 10)
			r.mode = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
		else
			r.mode = 3'($urandom_range(MODE_CLAMP, MODE_PINGPONG));
		r.elapsed_time = $urandom;
		r.loop_length  = $urandom;
		pick = $urandom_range(0, 7);
		case (pick)
			0: ;
			1: r.loop_length = $urandom_range(1, 16);
			2: r.elapsed_time = r.loop_length + $urandom_range(0, 4) - 2;
			3: begin
				r.loop_length  = $urandom_range(1, 1000);
				r.elapsed_time = r.loop_length * $urandom_range(0, 50) + $urandom_range(0, 3)
					- 1;
			end
			4: begin
				r.loop_length = '0;
				if ($urandom_range(0, 3) == 0)
					r.elapsed_time = '0;
			end
			5: begin
				r.elapsed_time = $urandom_range(0, 40);
				r.loop_length  = $urandom_range(0, 20);
			end
			6: r.loop_length = 1 << $urandom_range(0, FIELD_W - 1);
			default: r.loop_length = r.elapsed_time >> $urandom_range(1, FIELD_W - 1);
		endcase
		return r;
	endfunction

	function automatic int unsigned idle_cycles(bit on);
		return on ? $urandom_range(0, 9) : 0;
	endfunction

	task automatic report_mismatch(string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
	endtask

	// Offer one request and record its expected result once it is taken.
	task automatic offer_request(req_t r);
		int unsigned gap;
		gap = idle_cycles(req_idle_on);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		expected_keys.push_back(loop_key_of(r));
	endtask

	task automatic idle_requests();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Boundaries of every mode, zero lengths, odd and even periods and the invalid codes.
	task automatic test_directed();
		offer_request(make_req(MODE_CLAMP, 0, 0));
		offer_request(make_req(MODE_CLAMP, 5, 0));
		offer_request(make_req(MODE_CLAMP, 1000, 1000));
		offer_request(make_req(MODE_CLAMP, T_MAX, T_MAX - 1));
		offer_request(make_req(MODE_CLAMP, 3, T_MAX));
		offer_request(make_req(MODE_INFINITE, T_MAX, 0));
		offer_request(make_req(MODE_INFINITE, 0, T_MAX));
		offer_request(make_req(MODE_REPEAT, 12345, 0));
		offer_request(make_req(MODE_REPEAT, 700, 700));
		offer_request(make_req(MODE_REPEAT, 701, 700));
		offer_request(make_req(MODE_REPEAT, T_MAX, 1));
		offer_request(make_req(MODE_REPEAT, T_MAX, T_MAX - 1));
		offer_request(make_req(MODE_REPEAT, 2100, 700));
		offer_request(make_req(MODE_PINGPONG, 50, 100));
		offer_request(make_req(MODE_PINGPONG, 100, 100));
		offer_request(make_req(MODE_PINGPONG, 9, 0));
		offer_request(make_req(MODE_PINGPONG, 250, 100));
		offer_request(make_req(MODE_PINGPONG, 350, 100));
		offer_request(make_req(MODE_PINGPONG, 200, 100));
		offer_request(make_req(MODE_PINGPONG, T_MAX, 1));
		offer_request(make_req(MODE_PINGPONG, T_MAX, 2));
		for (int m = MODE_BAD_LO; m <= MODE_BAD_HI; m++)
			offer_request(make_req(3'(m), T_MAX, T_MAX));
		idle_requests();
	endtask

	// Hold the response side for a long stretch so the pipeline fills and stalls requests.
	task automatic test_backpressure();
		req_idle_on = 1'b0;
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
			for (int i = 0; i < 120; i++)
				offer_request(random_request());
		join
		idle_requests();
	endtask

	// Random requests, with idle stretches switched on and off on both sides.
	task automatic test_random_mix();
		for (int i = 0; i < 1080; i++) begin
			if (i % 90 == 0) begin
				req_idle_on = ($urandom_range(0, 2) != 0);
				rsp_idle_on <= ($urandom_range(0, 2) != 0);
			end
			offer_request(random_request());
		end
		idle_requests();
	endtask

	// The response side waits a drawn number of cycles before taking each result.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			rsp_gap = idle_cycles(rsp_idle_on);
		else if (rsp_gap != 0)
			rsp_gap--;
		rsp_stall <= hold_on || (rsp_gap != 0);
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_keys.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = expected_keys.pop_front();
				if (rsp.key_time !== want.key_time)
					report_mismatch($sformatf("key_time %0h, expected %0h",
						rsp.key_time, want.key_time));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, want.status));
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_mix();
		while (expected_keys.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
